// ===== sv/vwcs_pkg.sv =====
// Shared types and constants for the VWAP crossover signal block.
package vwcs_pkg;

    localparam int HISTORY_DEPTH_DEF = 1024;

    localparam int TIME_W     = 40;
    localparam int TURN_W     = 48;
    localparam int VOL_W      = 32;
    localparam int SUM_W      = 64;
    localparam int AVG_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int SWIN_W     = 20;
    localparam int CONF_W     = 10;
    localparam int MINH_W     = 16;
    localparam int TICKS_W    = 16;
    localparam int RUN_W      = 11;
    localparam int ENTRY_W    = TIME_W + TURN_W + VOL_W;
    localparam int QUO_W      = SUM_W + FRAC_W;

    localparam logic [SWIN_W-1:0] SHORT_WINDOW_RST  = 20'd360;
    localparam logic [SWIN_W-1:0] LONG_WINDOW_RST   = 20'd600;
    localparam logic [CONF_W-1:0] CONFIRM_COUNT_RST = 10'd100;
    localparam logic [MINH_W-1:0] MIN_HISTORY_RST   = 16'd500;

    localparam logic [1:0] REG_SHORT_WINDOW  = 2'd0;
    localparam logic [1:0] REG_LONG_WINDOW   = 2'd1;
    localparam logic [1:0] REG_CONFIRM_COUNT = 2'd2;
    localparam logic [1:0] REG_MIN_HISTORY   = 2'd3;

    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_BUY  = 2'd1;
    localparam logic [1:0] SIG_SELL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DATA,
        ST_DIV_SHORT,
        ST_WAIT_SHORT,
        ST_DIV_LONG,
        ST_WAIT_LONG,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] num;
        logic [SUM_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [AVG_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== sv/vwcs_ram.sv =====
// Generic single-port synchronous RAM with registered read.
module vwcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/vwcs_div.sv =====
// Bit-serial restoring divider: floor(num * 2^16 / den), saturated to 48 bits.
module vwcs_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  vwcs_pkg::div_req_t req,
    output vwcs_pkg::div_rsp_t rsp
);

    localparam int QW = vwcs_pkg::QUO_W;
    localparam int SW = vwcs_pkg::SUM_W;
    localparam int AW = vwcs_pkg::AVG_W;
    localparam int CW = $clog2(QW + 1);

    logic [SW:0]   rem_reg, rem_next;
    logic [QW-1:0] dvd_reg, dvd_next;
    logic [QW-1:0] quo_reg, quo_next;
    logic [SW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [SW:0]   trial;

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[SW-1:0], dvd_reg[QW-1]};
        if (req.start) begin
            rem_next  = '0;
            dvd_next  = {req.num, {vwcs_pkg::FRAC_W{1'b0}}};
            quo_next  = '0;
            den_next  = req.den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(QW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = (|quo_reg[QW-1:AW]) ? {AW{1'b1}} : quo_reg[AW-1:0];

endmodule

// ===== sv/vwap_crossover_signal.sv =====
// Dual-window VWAP crossover: tick history walk, averages and buy/sell signal.
// Per input beat the tick history is walked with one RAM read per entry, up to HISTORY_DEPTH
// entries, then each average is an 80-step divide (skipped for a window with zero volume).
// One tick at a time: the next tick is taken only after the result is loaded, which a busy
// output delays.
// Reset (aresetn low, synchronous) sets control and config to defaults; ring RAM not cleared.
module vwap_crossover_signal #(
    parameter int HISTORY_DEPTH = vwcs_pkg::HISTORY_DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    // tdata: tick_time[39:0], tick_turnover[87:40], tick_volume[119:88]
    input  logic [119:0]  s_tdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // tdata: short_average[47:0], long_average[95:48], above[96], signal[98:97],
    //        zero_volume[99], zero pad[103:100]
    output logic [103:0]  m_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int TW  = vwcs_pkg::TIME_W;
    localparam int RW  = vwcs_pkg::TURN_W;
    localparam int VW  = vwcs_pkg::VOL_W;
    localparam int SW  = vwcs_pkg::SUM_W;
    localparam int GW  = vwcs_pkg::AVG_W;

    // ---------------- configuration registers ----------------
    logic [vwcs_pkg::SWIN_W-1:0] short_win_reg, long_win_reg;
    logic [vwcs_pkg::CONF_W-1:0] confirm_reg;
    logic [vwcs_pkg::MINH_W-1:0] min_hist_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_win_reg <= vwcs_pkg::SHORT_WINDOW_RST;
            long_win_reg  <= vwcs_pkg::LONG_WINDOW_RST;
            confirm_reg   <= vwcs_pkg::CONFIRM_COUNT_RST;
            min_hist_reg  <= vwcs_pkg::MIN_HISTORY_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                vwcs_pkg::REG_SHORT_WINDOW:  short_win_reg <= pwdata[vwcs_pkg::SWIN_W-1:0];
                vwcs_pkg::REG_LONG_WINDOW:   long_win_reg  <= pwdata[vwcs_pkg::SWIN_W-1:0];
                vwcs_pkg::REG_CONFIRM_COUNT: confirm_reg   <= pwdata[vwcs_pkg::CONF_W-1:0];
                vwcs_pkg::REG_MIN_HISTORY:   min_hist_reg  <= pwdata[vwcs_pkg::MINH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            vwcs_pkg::REG_SHORT_WINDOW:  prdata = 32'(short_win_reg);
            vwcs_pkg::REG_LONG_WINDOW:   prdata = 32'(long_win_reg);
            vwcs_pkg::REG_CONFIRM_COUNT: prdata = 32'(confirm_reg);
            vwcs_pkg::REG_MIN_HISTORY:   prdata = 32'(min_hist_reg);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- state ----------------
    vwcs_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                write_slot_reg, write_slot_next;
    logic [vwcs_pkg::TICKS_W-1:0] ticks_reg, ticks_next;
    logic                         last_above_reg, last_above_next;
    logic [vwcs_pkg::RUN_W-1:0]   run_reg, run_next;

    // per-tick working registers
    logic [TW-1:0] now_reg, now_next;
    logic [RW-1:0] turn_reg, turn_next;
    logic [VW-1:0] vol_reg, vol_next;
    logic [SW-1:0] ts_s_reg, ts_s_next, vs_s_reg, vs_s_next;
    logic [SW-1:0] ts_l_reg, ts_l_next, vs_l_reg, vs_l_next;
    logic          act_s_reg, act_s_next, act_l_reg, act_l_next;
    logic [CW-1:0] idx_reg, idx_next, lim_reg, lim_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [GW-1:0] avg_s_reg, avg_s_next, avg_l_reg, avg_l_next;
    logic          zero_reg, zero_next;

    // output register
    logic [103:0]  out_data_reg, out_data_next;
    logic          out_valid_reg, out_valid_next;

    // ring RAM: {volume, turnover, time}
    logic                             ram_we, ram_re;
    logic [AW-1:0]                    ram_addr;
    logic [vwcs_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;
    logic [TW-1:0]                    e_time;
    logic [RW-1:0]                    e_turn;
    logic [VW-1:0]                    e_vol;

    vwcs_ram #(.WIDTH(vwcs_pkg::ENTRY_W), .DEPTH(HISTORY_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign e_time = ram_rdata[TW-1:0];
    assign e_turn = ram_rdata[TW+RW-1:TW];
    assign e_vol  = ram_rdata[TW+RW+VW-1:TW+RW];

    // shared divider for both averages
    vwcs_pkg::div_req_t div_req;
    vwcs_pkg::div_rsp_t div_rsp;

    vwcs_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SW] ? {SW{1'b1}} : s[SW-1:0];
    endfunction

    logic [16:0]   ticks_ext;
    logic [CW-1:0] lim_calc;
    logic          in_s, in_l;
    logic          above_w;
    logic [1:0]    sig_w;
    logic          s_fire;

    assign ticks_ext = {1'b0, ticks_reg};
    assign lim_calc  = (ticks_ext < 17'(HISTORY_DEPTH)) ? CW'(ticks_ext) : CW'(HISTORY_DEPTH);
    // entry is inside the window when time + window > now (41-bit compare)
    assign in_s = ({1'b0, e_time} + (TW+1)'(short_win_reg)) > {1'b0, now_reg};
    assign in_l = ({1'b0, e_time} + (TW+1)'(long_win_reg)) > {1'b0, now_reg};
    assign above_w = avg_s_reg > avg_l_reg;
    assign s_fire  = s_tvalid && s_tready;

    always_comb begin
        sig_w = vwcs_pkg::SIG_NONE;
        if (ticks_reg > min_hist_reg && confirm_reg != '0
            && run_reg >= vwcs_pkg::RUN_W'(confirm_reg) && last_above_reg == above_w) begin
            sig_w = above_w ? vwcs_pkg::SIG_BUY : vwcs_pkg::SIG_SELL;
        end
    end

    always_comb begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        ticks_next      = ticks_reg;
        last_above_next = last_above_reg;
        run_next        = run_reg;
        now_next        = now_reg;
        turn_next       = turn_reg;
        vol_next        = vol_reg;
        ts_s_next       = ts_s_reg;
        vs_s_next       = vs_s_reg;
        ts_l_next       = ts_l_reg;
        vs_l_next       = vs_l_reg;
        act_s_next      = act_s_reg;
        act_l_next      = act_l_reg;
        idx_next        = idx_reg;
        lim_next        = lim_reg;
        rd_ptr_next     = rd_ptr_reg;
        avg_s_next      = avg_s_reg;
        avg_l_next      = avg_l_reg;
        zero_next       = zero_reg;
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_addr        = rd_ptr_reg;
        ram_wdata       = {vol_reg, turn_reg, now_reg};
        div_req.start   = 1'b0;
        div_req.num     = ts_s_reg;
        div_req.den     = vs_s_reg;
        s_tready        = (state_reg == vwcs_pkg::ST_IDLE);

        unique case (state_reg)
            vwcs_pkg::ST_IDLE: begin
                if (s_fire) begin
                    now_next    = s_tdata[TW-1:0];
                    turn_next   = s_tdata[TW+RW-1:TW];
                    vol_next    = s_tdata[TW+RW+VW-1:TW+RW];
                    ts_s_next   = SW'(s_tdata[TW+RW-1:TW]);
                    ts_l_next   = SW'(s_tdata[TW+RW-1:TW]);
                    vs_s_next   = SW'(s_tdata[TW+RW+VW-1:TW+RW]);
                    vs_l_next   = SW'(s_tdata[TW+RW+VW-1:TW+RW]);
                    act_s_next  = 1'b1;
                    act_l_next  = 1'b1;
                    zero_next   = 1'b0;
                    idx_next    = '0;
                    lim_next    = lim_calc;
                    rd_ptr_next = (write_slot_reg == '0) ? AW'(HISTORY_DEPTH - 1)
                                                         : write_slot_reg - 1'b1;
                    state_next  = (lim_calc == '0) ? vwcs_pkg::ST_DIV_SHORT
                                                   : vwcs_pkg::ST_ADDR;
                end
            end
            vwcs_pkg::ST_ADDR: begin
                ram_re     = 1'b1;
                state_next = vwcs_pkg::ST_DATA;
            end
            vwcs_pkg::ST_DATA: begin
                // each window stops at its first entry that is too old
                if (act_s_reg && in_s) begin
                    ts_s_next = sat_add(ts_s_reg, SW'(e_turn));
                    vs_s_next = sat_add(vs_s_reg, SW'(e_vol));
                end
                if (act_l_reg && in_l) begin
                    ts_l_next = sat_add(ts_l_reg, SW'(e_turn));
                    vs_l_next = sat_add(vs_l_reg, SW'(e_vol));
                end
                act_s_next  = act_s_reg && in_s;
                act_l_next  = act_l_reg && in_l;
                idx_next    = idx_reg + 1'b1;
                rd_ptr_next = (rd_ptr_reg == '0) ? AW'(HISTORY_DEPTH - 1) : rd_ptr_reg - 1'b1;
                if ((act_s_next || act_l_next) && (idx_next < lim_reg)) begin
                    state_next = vwcs_pkg::ST_ADDR;
                end else begin
                    state_next = vwcs_pkg::ST_DIV_SHORT;
                end
            end
            vwcs_pkg::ST_DIV_SHORT: begin
                if (vs_s_reg == '0) begin
                    avg_s_next = '0;
                    zero_next  = 1'b1;
                    state_next = vwcs_pkg::ST_DIV_LONG;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = vwcs_pkg::ST_WAIT_SHORT;
                end
            end
            vwcs_pkg::ST_WAIT_SHORT: begin
                if (div_rsp.done) begin
                    avg_s_next = div_rsp.quo;
                    state_next = vwcs_pkg::ST_DIV_LONG;
                end
            end
            vwcs_pkg::ST_DIV_LONG: begin
                div_req.num = ts_l_reg;
                div_req.den = vs_l_reg;
                if (vs_l_reg == '0) begin
                    avg_l_next = '0;
                    zero_next  = 1'b1;
                    state_next = vwcs_pkg::ST_FINISH;
                end else begin
                    div_req.start = 1'b1;
                    state_next    = vwcs_pkg::ST_WAIT_LONG;
                end
            end
            vwcs_pkg::ST_WAIT_LONG: begin
                if (div_rsp.done) begin
                    avg_l_next = div_rsp.quo;
                    state_next = vwcs_pkg::ST_FINISH;
                end
            end
            vwcs_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, zero_reg, sig_w, above_w, avg_l_reg, avg_s_reg};
                    if (ticks_reg != '0 && above_w == last_above_reg) begin
                        run_next = (run_reg == '1) ? run_reg : run_reg + 1'b1;
                    end else begin
                        run_next = vwcs_pkg::RUN_W'(1);
                    end
                    last_above_next = above_w;
                    ram_we          = 1'b1;
                    ram_addr        = write_slot_reg;
                    write_slot_next = (write_slot_reg == AW'(HISTORY_DEPTH - 1)) ? '0
                                                                 : write_slot_reg + 1'b1;
                    ticks_next      = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
                    state_next      = vwcs_pkg::ST_IDLE;
                end
            end
            default: state_next = vwcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= vwcs_pkg::ST_IDLE;
            write_slot_reg <= '0;
            ticks_reg      <= '0;
            last_above_reg <= 1'b0;
            run_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            ticks_reg      <= ticks_next;
            last_above_reg <= last_above_next;
            run_reg        <= run_next;
            out_valid_reg  <= out_valid_next;
        end
        now_reg      <= now_next;
        turn_reg     <= turn_next;
        vol_reg      <= vol_next;
        ts_s_reg     <= ts_s_next;
        vs_s_reg     <= vs_s_next;
        ts_l_reg     <= ts_l_next;
        vs_l_reg     <= vs_l_next;
        act_s_reg    <= act_s_next;
        act_l_reg    <= act_l_next;
        idx_reg      <= idx_next;
        lim_reg      <= lim_next;
        rd_ptr_reg   <= rd_ptr_next;
        avg_s_reg    <= avg_s_next;
        avg_l_reg    <= avg_l_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- assertions ----------------
    a_sig_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[98:97] != 2'd3)
        else $error("illegal signal code on output");

    a_buy_above: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[98:97] == vwcs_pkg::SIG_BUY) |-> m_tdata[96])
        else $error("buy signal without short above long");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == vwcs_pkg::ST_WAIT_SHORT
                          || state_reg == vwcs_pkg::ST_WAIT_LONG))
        else $error("divider finished outside a wait state");

    a_ram_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("ring read and write in the same cycle");

endmodule
